FILE: sv/rgbc_pkg.sv
// rgbc_pkg: types and constants shared by the 3x3 RGB convolution block.
// No dependencies; used by the front, queue, back and top-level modules.
package rgbc_pkg;

  localparam int unsigned KSIZE = 3;
  localparam int unsigned NTAPS = KSIZE * KSIZE;
  localparam int unsigned PIX_W = 24;
  localparam int unsigned POS_W = 10;
  localparam int unsigned ACC_W = 21;
  localparam int unsigned REM_W = 18;
  localparam logic [7:0] PIX_MAX = 8'd255;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COEFF_TOP = 3'd0,
    REG_COEFF_MID = 3'd1,
    REG_COEFF_BOT = 3'd2,
    REG_DIVISOR   = 3'd3,
    REG_WIDTH     = 3'd4,
    REG_HEIGHT    = 3'd5
  } cfg_reg_t;

  // one window handed from front to back; tap r*3+c is window row r, column c
  typedef struct packed {
    logic [NTAPS-1:0][PIX_W-1:0] win;
    logic [POS_W-1:0]            row;
    logic [POS_W-1:0]            col;
    logic                        frame_end;
  } win_item_t;

endpackage

FILE: sv/rgbc_front.sv
// rgbc_front: pixel intake, raster counters, two line stores and 3x3 window.
// Pushes one window per interior pixel into the queue. Depends on rgbc_pkg.
module rgbc_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rgbc_pkg::PIX_W-1:0]     pix,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] img_w,
  input  logic [10:0]                    img_h,
  output logic                           q_valid,
  input  logic                           q_ready,
  output rgbc_pkg::win_item_t            q_item
);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = $clog2(MAX_WIDTH);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_UPD  = 2'b10
  } fstate_t;

  fstate_t state_r, state_nxt;
  logic [WW-1:0] col_r, col_nxt;
  logic [9:0]    row_r, row_nxt;
  logic [WW-1:0] col_eff;
  logic [9:0]    row_eff;
  logic          last_col, last_row, accept, interior, go;

  logic [rgbc_pkg::PIX_W-1:0] line0 [MAX_WIDTH];
  logic [rgbc_pkg::PIX_W-1:0] line1 [MAX_WIDTH];
  logic [rgbc_pkg::PIX_W-1:0] pix_r, rd1_r, rd2_r;
  logic [WW-1:0]              colq_r;
  logic [9:0]                 rowq_r;
  logic                       lastq_r;
  logic [rgbc_pkg::KSIZE-1:0][rgbc_pkg::KSIZE-1:0][rgbc_pkg::PIX_W-1:0] win_r, win_nxt;

  assign in_ready = (state_r == F_IDLE);
  assign accept   = in_valid && in_ready;

  // clamp position when the image size shrank mid-frame
  assign col_eff  = (col_r >= img_w) ? img_w - WW'(1) : col_r;
  assign row_eff  = ({1'b0, row_r} >= img_h) ? 10'(img_h - 11'd1) : row_r;
  assign last_col = (col_r >= img_w - WW'(1));
  assign last_row = ({1'b0, row_r} >= img_h - 11'd1);

  // raster counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 10'd1;
      end else begin
        col_nxt = col_r + WW'(1);
      end
    end
  end

  // shifted window
  always_comb begin
    for (int r = 0; r < rgbc_pkg::KSIZE; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = rd2_r;
    win_nxt[1][2] = rd1_r;
    win_nxt[2][2] = pix_r;
  end

  assign interior = (rowq_r >= 10'd2) && (colq_r >= WW'(2));
  assign go       = (state_r == F_UPD) && (!interior || q_ready);
  assign q_valid  = (state_r == F_UPD) && interior;

  always_comb begin
    for (int r = 0; r < rgbc_pkg::KSIZE; r++) begin
      for (int c = 0; c < rgbc_pkg::KSIZE; c++) begin
        q_item.win[r*rgbc_pkg::KSIZE + c] = win_nxt[r][c];
      end
    end
    q_item.row       = rowq_r - 10'd1;
    q_item.col       = 10'(colq_r - WW'(1));
    q_item.frame_end = lastq_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (accept) state_nxt = F_UPD;
      F_UPD:   if (go) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  // line store read on accept, write back when the window moves
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r   <= pix;
      colq_r  <= col_eff;
      rowq_r  <= row_eff;
      lastq_r <= last_col && last_row;
      rd1_r   <= line0[col_eff[CW-1:0]];
      rd2_r   <= line1[col_eff[CW-1:0]];
    end
    if (go) begin
      line0[colq_r[CW-1:0]] <= pix_r;
      line1[colq_r[CW-1:0]] <= rd1_r;
      win_r <= win_nxt;
    end
  end

endmodule

FILE: sv/rgbc_queue.sv
// rgbc_queue: two-entry queue of windows between front and back.
// Depends on rgbc_pkg.
module rgbc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  rgbc_pkg::win_item_t wr_item,
  output logic                rd_valid,
  input  logic                rd_ready,
  output rgbc_pkg::win_item_t rd_item
);
  rgbc_pkg::win_item_t mem [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wr_item;
  end

endmodule

FILE: sv/rgbc_back.sv
// rgbc_back: per-window multiply-accumulate, iterative divide and clamp,
// with the output register. Depends on rgbc_pkg.
module rgbc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  rgbc_pkg::win_item_t q_item,
  input  logic [71:0]         coeffs,
  input  logic [9:0]          div,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic [9:0]          out_row,
  output logic [9:0]          out_col,
  output logic                out_frame_end
);
  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MAC  = 5'b00010,
    B_PREP = 5'b00100,
    B_DIV  = 5'b01000,
    B_HOLD = 5'b10000
  } bstate_t;

  bstate_t state_r, state_nxt;
  rgbc_pkg::win_item_t it_r;
  logic [3:0] tap_r;
  logic [2:0] bit_r;
  logic signed [rgbc_pkg::ACC_W-1:0] acc_r [3];
  logic [rgbc_pkg::REM_W-1:0] rem_r [3];
  logic [7:0] quo_r [3];
  logic       neg_r [3];
  logic       sat_r [3];
  logic [7:0] res [3];
  logic [rgbc_pkg::REM_W-1:0] dsh;
  logic       out_valid_r, load_out, accept;

  assign q_ready  = (state_r == B_IDLE);
  assign accept   = q_valid && q_ready;
  assign load_out = (state_r == B_HOLD) && (!out_valid_r || out_ready);
  assign dsh      = rgbc_pkg::REM_W'(div) << bit_r;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (neg_r[ch])      res[ch] = 8'd0;
      else if (sat_r[ch]) res[ch] = rgbc_pkg::PIX_MAX;
      else                res[ch] = quo_r[ch];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (accept) state_nxt = B_MAC;
      B_MAC:   if (tap_r == 4'(rgbc_pkg::NTAPS - 1)) state_nxt = B_PREP;
      B_PREP:  state_nxt = B_DIV;
      B_DIV:   if (bit_r == 3'd0) state_nxt = B_HOLD;
      B_HOLD:  if (load_out) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath: one tap per cycle for all three channels, then one quotient bit
  always_ff @(posedge clk) begin
    if (accept) begin
      it_r  <= q_item;
      tap_r <= '0;
      for (int ch = 0; ch < 3; ch++) acc_r[ch] <= '0;
    end
    if (state_r == B_MAC) begin
      tap_r <= tap_r + 4'd1;
      for (int ch = 0; ch < 3; ch++) begin
        acc_r[ch] <= acc_r[ch] + rgbc_pkg::ACC_W'(
          $signed({1'b0, it_r.win[tap_r][8*ch +: 8]}) * $signed(coeffs[8*tap_r +: 8]));
      end
    end
    if (state_r == B_PREP) begin
      bit_r <= 3'd7;
      for (int ch = 0; ch < 3; ch++) begin
        neg_r[ch] <= acc_r[ch][rgbc_pkg::ACC_W-1] || (acc_r[ch] == '0);
        sat_r[ch] <= (acc_r[ch] >= $signed({3'b000, div, 8'd0}));
        rem_r[ch] <= acc_r[ch][rgbc_pkg::REM_W-1:0];
        quo_r[ch] <= 8'd0;
      end
    end
    if (state_r == B_DIV) begin
      bit_r <= bit_r - 3'd1;
      for (int ch = 0; ch < 3; ch++) begin
        if (rem_r[ch] >= dsh) begin
          rem_r[ch]        <= rem_r[ch] - dsh;
          quo_r[ch][bit_r] <= 1'b1;
        end
      end
    end
    if (load_out) begin
      out_red       <= res[0];
      out_green     <= res[1];
      out_blue      <= res[2];
      out_row       <= it_r.row;
      out_col       <= it_r.col;
      out_frame_end <= it_r.frame_end;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sv/rgb_convolution_3x3_unit.sv
// rgb_convolution_3x3_unit: top level of the 3x3 RGB convolution block.
// Depends on rgbc_pkg, rgbc_front, rgbc_queue and rgbc_back.

// Filters a raster-order RGB pixel stream with a configurable signed 3x3
// kernel, divides each channel sum by the divisor (truncating toward zero)
// and clamps it to 0..255. Only interior pixels give a result; out_row and
// out_col name the window centre and out_frame_end marks the last one. The
// front takes no new pixel until the last one is written back (registered
// line store read, then write back, which waits for queue space for an
// interior window). The back unit takes each window from the queue, runs 9
// multiply-accumulate steps, one setup and 8 quotient bits of the restoring
// divider, then hands off to the output register once any stalled result
// has left; it takes no new window before that. A two-entry queue lets the
// front run ahead of the back. Configuration is to be written through the
// cfg port only while the block is idle; the block does not enforce this.
module rgb_convolution_3x3_unit #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel_red,
  input  logic [7:0]  in_pixel_green,
  input  logic [7:0]  in_pixel_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [9:0]  out_row,
  output logic [9:0]  out_col,
  output logic        out_frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  logic [23:0] coeff_top_r, coeff_mid_r, coeff_bot_r;
  logic [9:0]  div_r, div_eff;
  logic [10:0] width_r, height_r, h_eff;
  logic [WW-1:0] w_eff;
  logic        q_wv, q_wr, q_rv, q_rr;
  rgbc_pkg::win_item_t q_wi, q_ri;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_top_r <= 24'd0;
      coeff_mid_r <= 24'h000100;
      coeff_bot_r <= 24'd0;
      div_r       <= 10'd1;
      width_r     <= 11'd1024;
      height_r    <= 11'd1024;
    end else if (cfg_valid) begin
      case (rgbc_pkg::cfg_reg_t'(cfg_index))
        rgbc_pkg::REG_COEFF_TOP: coeff_top_r <= cfg_data;
        rgbc_pkg::REG_COEFF_MID: coeff_mid_r <= cfg_data;
        rgbc_pkg::REG_COEFF_BOT: coeff_bot_r <= cfg_data;
        rgbc_pkg::REG_DIVISOR:   div_r       <= cfg_data[9:0];
        rgbc_pkg::REG_WIDTH:     width_r     <= cfg_data[10:0];
        rgbc_pkg::REG_HEIGHT:    height_r    <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // effective sizes and divisor
  assign div_eff = (div_r == 10'd0) ? 10'd1 : div_r;
  assign h_eff   = (height_r < 11'd3) ? 11'd3 : (height_r > 11'd1024) ? 11'd1024 : height_r;
  always_comb begin
    if (width_r < 11'd3)                        w_eff = WW'(3);
    else if ({21'd0, width_r} > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else                                        w_eff = WW'(width_r);
  end

  rgbc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .pix      ({in_pixel_blue, in_pixel_green, in_pixel_red}),
    .img_w    (w_eff),
    .img_h    (h_eff),
    .q_valid  (q_wv),
    .q_ready  (q_wr),
    .q_item   (q_wi)
  );

  rgbc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wv),
    .wr_ready (q_wr),
    .wr_item  (q_wi),
    .rd_valid (q_rv),
    .rd_ready (q_rr),
    .rd_item  (q_ri)
  );

  rgbc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_rv),
    .q_ready       (q_rr),
    .q_item        (q_ri),
    .coeffs        ({coeff_bot_r, coeff_mid_r, coeff_top_r}),
    .div           (div_eff),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_frame_end (out_frame_end)
  );

endmodule

FILE: sv/rgbc_checker.sv
// rgbc_checker: port-level assertions for rgb_convolution_3x3_unit,
// attached by the bind at the end of this file. Depends on the top level.
module rgbc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [9:0] out_row,
  input logic [9:0] out_col
);
  // a stalled result beat stays valid with its red value and row held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_row))
    else $error("result beat changed while stalled");

  // nothing leaves right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat out of reset");

  // no result names a centre in row 0 or column 0
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row != 10'd0) && (out_col != 10'd0))
    else $error("border pixel reported");

  // the front never takes pixel beats back to back
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("front took two beats back to back");

endmodule

bind rgb_convolution_3x3_unit rgbc_checker u_rgbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_red   (out_red),
  .out_row   (out_row),
  .out_col   (out_col)
);
